### design/tcon_pkg.sv
`timescale 1ns / 1ps

package tcon_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int CELL_W  = 16;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 11;

	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0]  CHAR_BLANK     = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_COLOR    = 8'd3;

	typedef struct packed {
		logic item_ld;
		logic ptr_clr;
		logic ptr_ld_scroll;
		logic ptr_ld_lastrow;
		logic ptr_inc;
		logic wr_fill_rst;
		logic wr_fill;
		logic wr_chr;
		logic wr_bs;
		logic rd_copy;
		logic rd_cap;
		logic cur_home;
		logic cur_adv;
		logic cur_nl;
		logic cur_bs;
	} cmd_t;

	typedef struct packed {
		logic ptr_last;
		logic row_last;
		logic col_last;
		logic col_zero;
	} sts_t;

endpackage

### design/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// A put that scrolls adds a row copy and last-row blank, one store cell
// per cycle on one write port. One item at a time: the next start is
// taken the cycle after done.
// Reset: cursor homed, color 3, then a fill of all COLUMNS*ROWS cells with busy high.
// done is a one-cycle strobe; the receiver cannot stall.

module text_console_cursor_scroll #(
	parameter int COLUMNS = tcon_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcon_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tcon_pkg::FUNC_W-1:0]   func,
	input  logic [tcon_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcon_pkg::IDX_W-1:0]    cell_index,
	output logic                          done,
	output logic [tcon_pkg::POS_W-1:0]    cursor_pos,
	output logic [tcon_pkg::CELL_W-1:0]   cell_value,
	input  logic                          cfg_we,
	input  logic [tcon_pkg::COLOR_W-1:0]  cfg_wdata
);

	tcon_pkg::cmd_t cmd;
	tcon_pkg::sts_t sts;

	tcon_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func),
		.char_code (char_code),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	tcon_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.char_code  (char_code),
		.cell_index (cell_index),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cursor_pos (cursor_pos),
		.cell_value (cell_value)
	);

endmodule

### design/tcon_ram.sv
`timescale 1ns / 1ps

module tcon_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/tcon_ctrl.sv
`timescale 1ns / 1ps

module tcon_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tcon_pkg::FUNC_W-1:0]  func,
	input  logic [tcon_pkg::CHAR_W-1:0]  char_code,
	input  tcon_pkg::sts_t               sts,
	output tcon_pkg::cmd_t               cmd,
	output logic                         busy,
	output logic                         done
);

	localparam logic [3:0] S_INIT      = 4'd0;
	localparam logic [3:0] S_IDLE      = 4'd1;
	localparam logic [3:0] S_CHR       = 4'd2;
	localparam logic [3:0] S_NL        = 4'd3;
	localparam logic [3:0] S_BS        = 4'd4;
	localparam logic [3:0] S_READ      = 4'd5;
	localparam logic [3:0] S_READ_W    = 4'd6;
	localparam logic [3:0] S_CLEAR     = 4'd7;
	localparam logic [3:0] S_SCR_COPY  = 4'd8;
	localparam logic [3:0] S_SCR_DRAIN = 4'd9;
	localparam logic [3:0] S_SCR_BLANK = 4'd10;
	localparam logic [3:0] S_DONE      = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd.wr_fill_rst = 1'b1;
				cmd.ptr_inc     = 1'b1;
				if (sts.ptr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.item_ld = 1'b1;
					case (func)
						tcon_pkg::FUNC_PUT: begin
							if (char_code == tcon_pkg::CHAR_NEWLINE) begin
								state_d = S_NL;
							end else if (char_code == tcon_pkg::CHAR_BACKSPACE) begin
								state_d = S_BS;
							end else begin
								state_d = S_CHR;
							end
						end
						tcon_pkg::FUNC_READ: begin
							state_d = S_READ;
						end
						tcon_pkg::FUNC_CLEAR: begin
							cmd.ptr_clr = 1'b1;
							state_d     = S_CLEAR;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_CHR: begin
				cmd.wr_chr = 1'b1;
				if (sts.col_last) begin
					cmd.cur_nl = 1'b1;
					if (sts.row_last) begin
						cmd.ptr_ld_scroll = 1'b1;
						state_d           = S_SCR_COPY;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					cmd.cur_adv = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_NL: begin
				cmd.cur_nl = 1'b1;
				if (sts.row_last) begin
					cmd.ptr_ld_scroll = 1'b1;
					state_d           = S_SCR_COPY;
				end else begin
					state_d = S_DONE;
				end
			end
			S_BS: begin
				if (!sts.col_zero) begin
					cmd.wr_bs  = 1'b1;
					cmd.cur_bs = 1'b1;
				end
				state_d = S_DONE;
			end
			S_READ: begin
				state_d = S_READ_W;
			end
			S_READ_W: begin
				cmd.rd_cap = 1'b1;
				state_d    = S_DONE;
			end
			S_CLEAR: begin
				cmd.wr_fill = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (sts.ptr_last) begin
					cmd.cur_home = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_SCR_COPY: begin
				cmd.rd_copy = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (sts.ptr_last) begin
					state_d = S_SCR_DRAIN;
				end
			end
			S_SCR_DRAIN: begin
				cmd.ptr_ld_lastrow = 1'b1;
				state_d            = S_SCR_BLANK;
			end
			S_SCR_BLANK: begin
				cmd.wr_fill = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (sts.ptr_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

`ifndef ASSERT_OFF
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_drain_after_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCR_DRAIN) |-> ($past(state_q) == S_SCR_COPY))
		else $error("scroll drain not preceded by copy");
`endif

endmodule

### design/tcon_dp.sv
`timescale 1ns / 1ps

module tcon_dp #(
	parameter int COLUMNS = tcon_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcon_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcon_pkg::cmd_t                cmd,
	output tcon_pkg::sts_t                sts,
	input  logic [tcon_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcon_pkg::IDX_W-1:0]    cell_index,
	input  logic                          cfg_we,
	input  logic [tcon_pkg::COLOR_W-1:0]  cfg_wdata,
	output logic [tcon_pkg::POS_W-1:0]    cursor_pos,
	output logic [tcon_pkg::CELL_W-1:0]   cell_value
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (AW > tcon_pkg::POS_W) ? AW : tcon_pkg::POS_W;
	localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

	localparam logic [tcon_pkg::CELL_W-1:0] RESET_CELL =
		{tcon_pkg::RESET_COLOR, tcon_pkg::CHAR_BLANK};

	logic [tcon_pkg::COLOR_W-1:0] color_q;
	logic [tcon_pkg::CHAR_W-1:0]  ch_q;
	logic [AW-1:0]                idx_addr_q;
	logic                         in_range_q;
	logic [tcon_pkg::CELL_W-1:0]  cell_q;

	logic [AW-1:0] ptr_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] row_base_q;

	logic          copy_vld_s1;
	logic [AW-1:0] dst_s1;

	logic [AW-1:0] pos;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] idx_ext;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tcon_pkg::CELL_W-1:0] ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [tcon_pkg::CELL_W-1:0] ram_rdata;

	assign pos     = row_base_q + AW'(col_q);
	assign pos_ext = PW'(pos);
	assign idx_ext = PW'(cell_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tcon_pkg::RESET_COLOR;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_ld) begin
			ch_q       <= char_code;
			idx_addr_q <= idx_ext[AW-1:0];
			in_range_q <= (idx_ext < PW'(CELLS));
			cell_q     <= '0;
		end else if (cmd.rd_cap) begin
			cell_q <= in_range_q ? ram_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.ptr_ld_scroll) begin
			ptr_q <= AW'(COLUMNS);
		end else if (cmd.ptr_ld_lastrow) begin
			ptr_q <= AW'(LAST_ROW_BASE);
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			row_base_q <= '0;
		end else if (cmd.cur_home) begin
			row_q      <= '0;
			col_q      <= '0;
			row_base_q <= '0;
		end else if (cmd.cur_nl) begin
			col_q <= '0;
			if (!sts.row_last) begin
				row_q      <= row_q + RW'(1);
				row_base_q <= row_base_q + AW'(COLUMNS);
			end
		end else if (cmd.cur_adv) begin
			col_q <= col_q + CW'(1);
		end else if (cmd.cur_bs) begin
			col_q <= col_q - CW'(1);
		end
	end

	// scroll copy: read source now, write one row up next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_vld_s1 <= 1'b0;
		end else begin
			copy_vld_s1 <= cmd.rd_copy;
		end
	end

	always_ff @(posedge clk) begin
		dst_s1 <= ptr_q - AW'(COLUMNS);
	end

	always_comb begin
		ram_we    = 1'b1;
		ram_waddr = ptr_q;
		ram_wdata = {color_q, tcon_pkg::CHAR_BLANK};
		if (copy_vld_s1) begin
			ram_waddr = dst_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.wr_fill_rst) begin
			ram_wdata = RESET_CELL;
		end else if (cmd.wr_chr) begin
			ram_waddr = pos;
			ram_wdata = {color_q, ch_q};
		end else if (cmd.wr_bs) begin
			ram_waddr = pos - AW'(1);
		end else if (!cmd.wr_fill) begin
			ram_we = 1'b0;
		end
	end

	assign ram_raddr = cmd.rd_copy ? ptr_q : idx_addr_q;

	tcon_ram #(
		.WIDTH (tcon_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign sts.ptr_last = (ptr_q == AW'(CELLS - 1));
	assign sts.row_last = (row_q == RW'(ROWS - 1));
	assign sts.col_last = (col_q == CW'(COLUMNS - 1));
	assign sts.col_zero = (col_q == '0);

	assign cursor_pos = pos_ext[tcon_pkg::POS_W-1:0];
	assign cell_value = cell_q;

`ifndef ASSERT_OFF
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> !(cmd.wr_fill || cmd.wr_fill_rst || cmd.wr_chr || cmd.wr_bs))
		else $error("scroll copy write collides with another write");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import tcon_pkg::*;

	localparam int COLS        = COLUMNS_DEF;
	localparam int LINES       = ROWS_DEF;
	localparam int CELLS       = COLS * LINES;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int LIMIT       =
		(PHASES * PHASE_ITEMS + 200) * (8 * CELLS + 64) + 8 * CELLS;
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CELL_W-1:0] val;
	} con_result_t;

	typedef struct packed {
		logic [FUNC_W-1:0] f;
		logic [CHAR_W-1:0] c;
		logic [IDX_W-1:0]  i;
		logic [6:0]        reps;
		logic              typed;
		logic [POS_W-1:0]  pos;
		logic [CELL_W-1:0] val;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [FUNC_W-1:0]   func = FUNC_PUT;
	logic [CHAR_W-1:0]   char_code = '0;
	logic [IDX_W-1:0]    cell_index = '0;
	logic                cfg_we = 1'b0;
	logic [COLOR_W-1:0]  cfg_wdata = '0;
	logic                busy;
	logic                done;
	logic [POS_W-1:0]    cursor_pos;
	logic [CELL_W-1:0]   cell_value;

	logic [CELL_W-1:0]   shadow [CELLS];
	int                  cur_row;
	int                  cur_col;
	logic [COLOR_W-1:0]  attr;

	con_result_t         expected_q [$];
	con_result_t         head;
	int                  mismatches = 0;
	int                  burst_left = 0;
	int                  cycles = 0;

	// read-back rows typed in at reset color 3
	dir_row_t directed [25] = '{
		'{FUNC_READ,  8'h00,          11'd0,    7'd1,  1'b1, 11'd0,    16'h0320},
		'{FUNC_READ,  8'h00,          11'd1999, 7'd1,  1'b1, 11'd0,    16'h0320},
		'{FUNC_READ,  8'h00,          11'd2000, 7'd1,  1'b1, 11'd0,    16'h0000},
		'{FUNC_READ,  8'hFF,          11'd2047, 7'd1,  1'b1, 11'd0,    16'h0000},
		'{FUNC_NONE,  8'hFF,          11'd2047, 7'd1,  1'b1, 11'd0,    16'h0000},
		'{FUNC_PUT,   CHAR_BACKSPACE, 11'd0,    7'd1,  1'b1, 11'd0,    16'h0000},
		'{FUNC_PUT,   8'h41,          11'd0,    7'd1,  1'b1, 11'd1,    16'h0000},
		'{FUNC_PUT,   8'hFF,          11'd0,    7'd1,  1'b1, 11'd2,    16'h0000},
		'{FUNC_READ,  8'h00,          11'd1,    7'd1,  1'b1, 11'd2,    16'h03FF},
		'{FUNC_PUT,   CHAR_BACKSPACE, 11'd0,    7'd1,  1'b1, 11'd1,    16'h0000},
		'{FUNC_READ,  8'h00,          11'd1,    7'd1,  1'b1, 11'd1,    16'h0320},
		'{FUNC_READ,  8'h00,          11'd0,    7'd1,  1'b1, 11'd1,    16'h0341},
		'{FUNC_PUT,   CHAR_NEWLINE,   11'd0,    7'd1,  1'b1, 11'd80,   16'h0000},
		'{FUNC_PUT,   8'h00,          11'd0,    7'd1,  1'b1, 11'd81,   16'h0000},
		'{FUNC_READ,  8'h00,          11'd80,   7'd1,  1'b1, 11'd81,   16'h0300},
		'{FUNC_CLEAR, 8'h00,          11'd0,    7'd1,  1'b1, 11'd0,    16'h0000},
		'{FUNC_READ,  8'h00,          11'd80,   7'd1,  1'b1, 11'd0,    16'h0320},
		'{FUNC_PUT,   CHAR_NEWLINE,   11'd0,    7'd24, 1'b1, 11'd1920, 16'h0000},
		'{FUNC_PUT,   8'h5A,          11'd0,    7'd1,  1'b1, 11'd1921, 16'h0000},
		'{FUNC_PUT,   CHAR_NEWLINE,   11'd0,    7'd1,  1'b1, 11'd1920, 16'h0000},
		'{FUNC_READ,  8'h00,          11'd1840, 7'd1,  1'b1, 11'd1920, 16'h035A},
		'{FUNC_READ,  8'h00,          11'd1920, 7'd1,  1'b1, 11'd1920, 16'h0320},
		'{FUNC_PUT,   8'h78,          11'd0,    7'd80, 1'b1, 11'd1920, 16'h0000},
		'{FUNC_READ,  8'h00,          11'd1919, 7'd1,  1'b1, 11'd1920, 16'h0378},
		'{FUNC_PUT,   CHAR_BACKSPACE, 11'd0,    7'd1,  1'b1, 11'd1920, 16'h0000}
	};

	logic [COLOR_W-1:0] fixed_colors [4] = '{8'h00, 8'hFF, 8'h0F, 8'hF0};

	text_console_cursor_scroll i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.char_code  (char_code),
		.cell_index (cell_index),
		.done       (done),
		.cursor_pos (cursor_pos),
		.cell_value (cell_value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void blank_all();
		for (int k = 0; k < CELLS; k++)
			shadow[k] = {attr, CHAR_BLANK};
	endfunction

	function automatic void roll_up();
		for (int k = 0; k < CELLS - COLS; k++)
			shadow[k] = shadow[k + COLS];
		for (int k = CELLS - COLS; k < CELLS; k++)
			shadow[k] = {attr, CHAR_BLANK};
		cur_row = LINES - 1;
	endfunction

	function automatic void line_feed();
		cur_col = 0;
		cur_row++;
		if (cur_row >= LINES)
			roll_up();
	endfunction

	function automatic con_result_t console_step(input logic [FUNC_W-1:0] f,
			input logic [CHAR_W-1:0] c, input logic [IDX_W-1:0] i);
		con_result_t r;
		r.val = '0;
		case (f)
		FUNC_PUT: begin
			if (c == CHAR_NEWLINE) begin
				line_feed();
			end else if (c == CHAR_BACKSPACE) begin
				if (cur_col > 0) begin
					cur_col--;
					shadow[cur_row * COLS + cur_col] = {attr, CHAR_BLANK};
				end
			end else begin
				shadow[cur_row * COLS + cur_col] = {attr, c};
				cur_col++;
				if (cur_col >= COLS)
					line_feed();
			end
		end
		FUNC_READ: begin
			if (i < CELLS)
				r.val = shadow[i];
		end
		FUNC_CLEAR: begin
			blank_all();
			cur_row = 0;
			cur_col = 0;
		end
		default: ;
		endcase
		r.pos = POS_W'(cur_row * COLS + cur_col);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
			input logic [IDX_W-1:0] i, input logic typed, input con_result_t want);
		con_result_t model;
		func       <= f;
		char_code  <= c;
		cell_index <= i;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		model = console_step(f, c, i);
		expected_q.push_back(typed ? want : model);
	endtask

	task automatic pace();
		int gap;
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			burst_left = $urandom_range(20, 60);
		end else begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(0, 10);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_attr(input logic [COLOR_W-1:0] v);
		start <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0 || busy);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		attr = v;
	endtask

	task automatic send_random();
		int k;
		int r;
		logic [FUNC_W-1:0] f;
		logic [CHAR_W-1:0] c;
		logic [IDX_W-1:0]  i;
		k = $urandom_range(0, 99);
		c = CHAR_W'($urandom_range(0, 255));
		i = IDX_W'($urandom_range(0, 2047));
		if (k < 72) begin
			f = FUNC_PUT;
			k = $urandom_range(0, 99);
			if (k < 10)
				c = CHAR_NEWLINE;
			else if (k < 16)
				c = CHAR_BACKSPACE;
		end else if (k < 94) begin
			f = FUNC_READ;
			k = $urandom_range(0, 99);
			if (k < 40) begin
				r = (k < 15 && cur_row > 0) ? cur_row - 1 : cur_row;
				i = IDX_W'(r * COLS + $urandom_range(0, COLS - 1));
			end else if (k < 85) begin
				i = IDX_W'($urandom_range(0, CELLS - 1));
			end else begin
				i = IDX_W'($urandom_range(CELLS, 2047));
			end
		end else if (k < 98) begin
			f = FUNC_NONE;
		end else begin
			f = FUNC_CLEAR;
		end
		send_item(f, c, i, 1'b0, '0);
		pace();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing pending, pos", cursor_pos, 0);
			end else begin
				head = expected_q.pop_front();
				if (cursor_pos !== head.pos)
					report_mismatch("cursor_pos", cursor_pos, head.pos);
				if (cell_value !== head.val)
					report_mismatch("cell_value", cell_value, head.val);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAIL text_console_cursor_scroll");
			$finish;
		end
	end

	initial begin
		con_result_t want;
		attr = RESET_COLOR;
		blank_all();
		cur_row = 0;
		cur_col = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[n]) begin
			for (int r = 0; r < directed[n].reps; r++) begin
				want.pos = directed[n].pos;
				want.val = directed[n].val;
				send_item(directed[n].f, directed[n].c, directed[n].i,
					directed[n].typed && (r == directed[n].reps - 1), want);
				pace();
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			write_attr(p < 4 ? fixed_colors[p] : COLOR_W'($urandom));
			repeat (PHASE_ITEMS) send_random();
		end

		start <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS text_console_cursor_scroll");
		else
			$display("FAIL text_console_cursor_scroll");
		$finish;
	end

endmodule
